/* rtl/core/spd_pkg.sv */
// Package with the sizes, codes and beat types of the shortest path distance core.
package spd_pkg;

  localparam int NUM_VERTICES = 8;
  localparam int WEIGHT_BITS  = 16;

  localparam int VERT_W  = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int CNT_W   = $clog2(NUM_VERTICES + 1);
  localparam int ADDR_W  = $clog2(NUM_VERTICES * NUM_VERTICES);
  localparam int DIST_W  = 20;
  localparam int SUM_W   = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  localparam int VFIELD_W = 3;
  localparam int WFIELD_W = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_RUN   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_RELAX,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic                action;
    logic [VFIELD_W-1:0] from_vertex;
    logic [VFIELD_W-1:0] to_vertex;
    logic [WFIELD_W-1:0] edge_weight;
    logic [VFIELD_W-1:0] source_vertex;
  } spd_in_t;

  typedef struct packed {
    logic [VFIELD_W-1:0] vertex;
    logic [DIST_W-1:0]   distance;
    logic                reachable;
    logic                last;
  } spd_out_t;

  typedef struct packed {
    logic              found;
    logic [DIST_W-1:0] best;
    logic [VERT_W-1:0] idx;
  } scan_t;

  typedef struct packed {
    logic              init;
    logic              src_valid;
    logic [VERT_W-1:0] src;
    logic              fin;
    logic [VERT_W-1:0] fin_idx;
    logic              relax;
    logic [VERT_W-1:0] relax_idx;
    logic [DIST_W-1:0] relax_dist;
  } cell_cmd_t;

  typedef struct packed {
    logic              reached;
    logic [DIST_W-1:0] path_len;
  } cell_view_t;

endpackage

/* rtl/core/spd_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module spd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/spd_cell.sv */
// One vertex cell: holds its distance and flags and passes the running minimum along the chain.
module spd_cell import spd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [VERT_W-1:0] idx,
  input  cell_cmd_t         cmd,
  input  scan_t             scan_in,
  output scan_t             scan_out,
  output cell_view_t        view
);

  logic [DIST_W-1:0] path_len;
  logic              reached;
  logic              done;
  logic              relax_hit;
  scan_t             scan_next;

  assign relax_hit = cmd.relax && (cmd.relax_idx == idx) && !done &&
                     (!reached || (cmd.relax_dist < path_len));

  always_comb begin
    scan_next = scan_in;
    if (!done && reached && (!scan_in.found || (path_len < scan_in.best))) begin
      scan_next.found = 1'b1;
      scan_next.best  = path_len;
      scan_next.idx   = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reached <= 1'b0;
      done    <= 1'b0;
    end else if (cmd.init) begin
      reached <= cmd.src_valid && (cmd.src == idx);
      done    <= 1'b0;
    end else begin
      if (cmd.fin && (cmd.fin_idx == idx)) begin
        done <= 1'b1;
      end
      if (relax_hit) begin
        reached <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      path_len <= '0;
    end else if (relax_hit) begin
      path_len <= cmd.relax_dist;
    end
    scan_out <= scan_next;
  end

  assign view.reached  = reached;
  assign view.path_len = path_len;

endmodule

/* rtl/core/shortest_path_distances_core.sv */
// Top level of the single-source shortest path core: edge RAM, vertex cell chain and sequencer.
//
//   channel  | dir | payload  | handshake
//   cmd      | in  | spd_in_t | cmd_valid / cmd_stall
//   res      | out | spd_out_t| res_valid / res_stall
//
// Edge writes are taken back to back.
// A run does k+1 minimum scans through the N-cell chain and k relaxation passes
// that read one edge RAM word a cycle, for k reached vertices, then gives N
// result beats, one per cycle when res_stall stays low.
// The edge matrix reads as zero after reset through per-entry valid flops.
// cmd_stall is high from a run beat until its last result beat is loaded.
module shortest_path_distances_core import spd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  spd_in_t  cmd,
  output logic     res_valid,
  input  logic     res_stall,
  output spd_out_t res
);

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]   cnt;
  logic               cnt_inc;
  logic [VERT_W-1:0]  u;
  logic [DIST_W-1:0]  u_dist;

  logic                                  accept;
  logic                                  wr_en;
  logic [ADDR_W-1:0]                     wr_addr;
  logic [WEIGHT_BITS-1:0]                wr_data;
  logic [ADDR_W-1:0]                     rd_addr;
  logic [WEIGHT_BITS-1:0]                rd_data;
  logic [NUM_VERTICES*NUM_VERTICES-1:0]  entry_valid;
  logic                                  rd_ok;
  logic                                  rel_valid;
  logic                                  rel_issue;
  logic [VERT_W-1:0]                     rel_idx;
  logic [WEIGHT_BITS-1:0]                weight;
  logic [SUM_W-1:0]                      sum;
  logic [DIST_W-1:0]                     cand;
  logic                                  load;
  logic                                  pick_end;
  logic                                  relax_end;

  cell_cmd_t  cell_cmd;
  scan_t      chain [NUM_VERTICES+1];
  cell_view_t views [NUM_VERTICES];
  scan_t      tail;

  assign tail      = chain[NUM_VERTICES];
  assign pick_end  = (state == ST_PICK) && (cnt == CNT_W'(NUM_VERTICES));
  assign relax_end = (state == ST_RELAX) && (cnt == CNT_W'(NUM_VERTICES));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && (cmd.action == ACT_RUN)) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (pick_end) begin
          state_next = tail.found ? ST_RELAX : ST_REPORT;
        end
      end
      ST_RELAX: begin
        if (relax_end) begin
          state_next = ST_PICK;
        end
      end
      ST_REPORT: begin
        if (load && (cnt == CNT_W'(NUM_VERTICES - 1))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall = 1'b1;
    load      = 1'b0;
    rel_issue = 1'b0;
    cnt_inc   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
      end
      ST_PICK: begin
        cnt_inc = 1'b1;
      end
      ST_RELAX: begin
        cnt_inc   = 1'b1;
        rel_issue = (cnt < CNT_W'(NUM_VERTICES));
      end
      ST_REPORT: begin
        load    = !res_valid || !res_stall;
        cnt_inc = load;
      end
      default: cmd_stall = 1'b1;
    endcase
  end

  assign accept  = cmd_valid && !cmd_stall;
  assign wr_en   = accept && (cmd.action == ACT_WRITE) &&
                   (int'(cmd.from_vertex) < NUM_VERTICES) &&
                   (int'(cmd.to_vertex) < NUM_VERTICES);
  assign wr_addr = ADDR_W'(int'(cmd.from_vertex) * NUM_VERTICES + int'(cmd.to_vertex));
  assign wr_data = WEIGHT_BITS'(cmd.edge_weight);
  assign rd_addr = ADDR_W'(int'(u) * NUM_VERTICES + int'(cnt[VERT_W-1:0]));

  assign weight = rd_ok ? rd_data : '0;
  assign sum    = SUM_W'(u_dist) + SUM_W'(weight);
  assign cand   = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);

  always_comb begin
    cell_cmd.init       = accept && (cmd.action == ACT_RUN);
    cell_cmd.src_valid  = int'(cmd.source_vertex) < NUM_VERTICES;
    cell_cmd.src        = VERT_W'(cmd.source_vertex);
    cell_cmd.fin        = pick_end && tail.found;
    cell_cmd.fin_idx    = tail.idx;
    cell_cmd.relax      = rel_valid && (weight != '0);
    cell_cmd.relax_idx  = rel_idx;
    cell_cmd.relax_dist = cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else if (cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rel_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      rel_valid <= rel_issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok   <= entry_valid[rd_addr];
    rel_idx <= cnt[VERT_W-1:0];
    if (pick_end) begin
      u      <= tail.idx;
      u_dist <= tail.best;
    end
  end

  spd_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (NUM_VERTICES * NUM_VERTICES)
  ) u_edges (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign chain[0] = '0;

  for (genvar i = 0; i < NUM_VERTICES; i++) begin : g_cell
    spd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (VERT_W'(i)),
      .cmd      (cell_cmd),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1]),
      .view     (views[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.vertex    <= VFIELD_W'(cnt[VERT_W-1:0]);
      res.distance  <= views[cnt[VERT_W-1:0]].reached ? views[cnt[VERT_W-1:0]].path_len : '0;
      res.reachable <= views[cnt[VERT_W-1:0]].reached;
      res.last      <= (cnt == CNT_W'(NUM_VERTICES - 1));
    end
  end

endmodule

/* rtl/core/spd_checker.sv */
// Port-level checks of the shortest path distance core, bound to the top level.
module spd_checker import spd_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     cmd_valid,
  input logic     cmd_stall,
  input spd_in_t  cmd,
  input logic     res_valid,
  input logic     res_stall,
  input spd_out_t res
);

  // A stalled result beat holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // Edge writes are taken one per cycle.
  a_write_rate: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd.action == ACT_WRITE) |=> !cmd_stall)
    else $error("stall raised after an edge write");

  // A run beat starts a search, which blocks the command channel.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd.action == ACT_RUN) |=> cmd_stall)
    else $error("command taken during a search");

  // An unreachable vertex reports a zero distance.
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.reachable |-> (res.distance == '0))
    else $error("unreachable vertex with nonzero distance");

endmodule

bind shortest_path_distances_core spd_checker u_spd_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for shortest_path_distances_core with its own Dijkstra predictor.
module tb_top;
  import spd_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int FLUSH_CYCLES = 2 * (NUM_VERTICES + 1) * (NUM_VERTICES + 1);

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  spd_in_t  cmd = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  spd_out_t res;

  logic [WEIGHT_BITS-1:0] edge_table [NUM_VERTICES*NUM_VERTICES];
  spd_out_t               pending_reports [$];
  bit                     idle_on = 1'b1;
  int unsigned            err_count = 0;
  int unsigned            beats_sent = 0;
  int unsigned            writes_sent = 0;
  int unsigned            runs_sent = 0;
  int unsigned            reports_seen = 0;
  int unsigned            cycle_count = 0;
  int                     stall_left = 0;

  shortest_path_distances_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_VERTICES * NUM_VERTICES; i++) begin
      edge_table[i] = '0;
    end
  end

  task automatic report_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // Computes the distance report of a search from src and queues one beat per vertex.
  function automatic void solve_from(input logic [VFIELD_W-1:0] src);
    int unsigned path_len [NUM_VERTICES];
    bit          seen [NUM_VERTICES];
    bit          done [NUM_VERTICES];
    int unsigned best;
    int unsigned cand;
    int unsigned w;
    int          u;
    spd_out_t    r;
    for (int v = 0; v < NUM_VERTICES; v++) begin
      path_len[v] = 0;
      seen[v] = 1'b0;
      done[v] = 1'b0;
    end
    if (src < NUM_VERTICES) seen[src] = 1'b1;
    for (int n = 0; n < NUM_VERTICES; n++) begin
      u = -1;
      best = 0;
      for (int v = 0; v < NUM_VERTICES; v++) begin
        if (!done[v] && seen[v] && (u < 0 || path_len[v] < best)) begin
          u = v;
          best = path_len[v];
        end
      end
      if (u < 0) break;
      done[u] = 1'b1;
      for (int v = 0; v < NUM_VERTICES; v++) begin
        w = 32'(edge_table[ADDR_W'(u * NUM_VERTICES + v)]);
        if (done[v] || w == 0) continue;
        cand = path_len[u] + w;
        if (cand > 32'(DIST_MAX)) cand = 32'(DIST_MAX);
        if (!seen[v] || cand < path_len[v]) begin
          path_len[v] = cand;
          seen[v] = 1'b1;
        end
      end
    end
    for (int v = 0; v < NUM_VERTICES; v++) begin
      r.vertex    = VFIELD_W'(v);
      r.distance  = seen[v] ? DIST_W'(path_len[v]) : '0;
      r.reachable = seen[v];
      r.last      = (v == NUM_VERTICES - 1);
      pending_reports.push_back(r);
    end
  endfunction

  task automatic send_beat(input spd_in_t b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    cmd       <= b;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    beats_sent++;
    if (b.action == ACT_WRITE) begin
      writes_sent++;
      if (b.from_vertex < NUM_VERTICES && b.to_vertex < NUM_VERTICES) begin
        edge_table[{b.from_vertex, b.to_vertex}] = b.edge_weight;
      end
    end else begin
      runs_sent++;
      solve_from(b.source_vertex);
    end
  endtask

  task automatic write_edge(input int unsigned from_v, input int unsigned to_v,
                            input logic [WFIELD_W-1:0] w);
    spd_in_t b;
    b.action        = ACT_WRITE;
    b.from_vertex   = VFIELD_W'(from_v);
    b.to_vertex     = VFIELD_W'(to_v);
    b.edge_weight   = w;
    b.source_vertex = VFIELD_W'($urandom);
    send_beat(b);
  endtask

  task automatic run_from(input int unsigned src);
    spd_in_t b;
    b.action        = ACT_RUN;
    b.from_vertex   = VFIELD_W'($urandom);
    b.to_vertex     = VFIELD_W'($urandom);
    b.edge_weight   = WFIELD_W'($urandom);
    b.source_vertex = VFIELD_W'(src);
    send_beat(b);
  endtask

  function automatic logic [WFIELD_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0, 1:       pick_weight = '0;
      2:          pick_weight = '1;
      3, 4, 5, 6: pick_weight = WFIELD_W'($urandom_range(1, 15));
      default:    pick_weight = WFIELD_W'($urandom);
    endcase
  endfunction

  task automatic test_empty_graph();
    run_from(0);
    run_from(NUM_VERTICES - 1);
  endtask

  // A chain of maximum weights gives the longest distances; a self loop must be ignored.
  task automatic test_weight_extremes();
    for (int v = 0; v < NUM_VERTICES - 1; v++) begin
      write_edge(v, v + 1, '1);
    end
    write_edge(3, 3, 16'h0001);
    run_from(0);
    write_edge(0, NUM_VERTICES - 1, 16'h0001);
    run_from(0);
    run_from(NUM_VERTICES - 1);
  endtask

  task automatic test_edge_removal();
    write_edge(3, 4, '0);
    run_from(0);
    run_from(2);
  endtask

  task automatic test_random_graphs(input int unsigned stop_at);
    int unsigned n_writes;
    int unsigned n_runs;
    while (beats_sent < stop_at) begin
      n_writes = $urandom_range(0, 12);
      repeat (n_writes) write_edge($urandom_range(0, 7), $urandom_range(0, 7), pick_weight());
      n_runs = $urandom_range(1, 3);
      repeat (n_runs) run_from($urandom_range(0, 7));
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    idle_on = 1'b0;
    test_random_graphs(beats_sent + count);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) res_stall <= 1'b0;
    end else if (idle_on && !rst && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15);
      res_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    spd_out_t want;
    if (!rst && res_valid && !res_stall) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        report_error($sformatf("unexpected result beat for vertex %0d", res.vertex));
      end else begin
        want = pending_reports.pop_front();
        if (res.vertex !== want.vertex)
          report_error($sformatf("vertex %0d, expected %0d", res.vertex, want.vertex));
        if (res.distance !== want.distance)
          report_error($sformatf("vertex %0d distance %0d, expected %0d",
                                 want.vertex, res.distance, want.distance));
        if (res.reachable !== want.reachable)
          report_error($sformatf("vertex %0d reachable %0b, expected %0b",
                                 want.vertex, res.reachable, want.reachable));
        if (res.last !== want.last)
          report_error($sformatf("vertex %0d last %0b, expected %0b",
                                 want.vertex, res.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d result beats outstanding.", pending_reports.size());
      $display("FAIL shortest_path_distances_core");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_graph();
    test_weight_extremes();
    test_edge_removal();
    test_random_graphs(beats_sent + 280);
    test_back_to_back(70);
    cmd_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    $display("Sent %0d edge writes and %0d searches; checked %0d distance beats.",
             writes_sent, runs_sent, reports_seen);
    if (err_count == 0) begin
      $display("PASS shortest_path_distances_core");
    end else begin
      $display("FAIL shortest_path_distances_core");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/spd_pkg.sv
rtl/core/spd_ram.sv
rtl/core/spd_cell.sv
rtl/core/shortest_path_distances_core.sv
rtl/core/spd_checker.sv
tb/tb_top.sv
